// File: hdl/single_byte_charset_codec_top_defines.svh
// assertion macros for the single-byte charset codec checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SINGLE_BYTE_CHARSET_CODEC_TOP_DEFINES_SVH
`define SINGLE_BYTE_CHARSET_CODEC_TOP_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/scc_pkg.sv
// shared constants, codes and controller/datapath structs for the charset codec
// no dependencies
`timescale 1ns / 1ps

package scc_pkg;

  localparam int unsigned MAX_PAGES = 8;
  localparam int unsigned PAGE_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PU_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned ENC_DEPTH = MAX_PAGES * 256;
  localparam int unsigned ENC_AW    = PAGE_W + 8;

  localparam logic [ENC_AW-1:0] ENC_LAST   = ENC_AW'(ENC_DEPTH - 1);
  localparam logic [PU_W-1:0]   PAGES_FULL = PU_W'(MAX_PAGES);

  localparam logic [2:0] CMD_CLEAR    = 3'd0;
  localparam logic [2:0] CMD_LOAD_DEC = 3'd1;
  localparam logic [2:0] CMD_LOAD_NRT = 3'd2;
  localparam logic [2:0] CMD_DECODE   = 3'd3;
  localparam logic [2:0] CMD_ENCODE   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNMAP  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic CFG_DEC_REPL = 1'b0;
  localparam logic CFG_ENC_REPL = 1'b1;

  localparam logic [15:0] UNMAPPED_CHAR = 16'hFFFD;
  localparam logic [15:0] DEC_REPL_RST  = 16'hFFFD;
  localparam logic [7:0]  ENC_REPL_RST  = 8'h3F;

  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;

  typedef struct packed {
    logic cap;
    logic sweep_start;
    logic sweep;
    logic exec;
    logic enc;
    logic res_sel_enc;
    logic hold_load;
    logic push_new;
    logic push_held;
  } scc_ctl_t;

  typedef struct packed {
    logic cmd_known;
    logic is_clear;
    logic swallow;
    logic need_enc;
    logic sweep_last;
    logic out_free;
  } scc_stat_t;

endpackage

// File: hdl/scc_dp.sv
// datapath: decode table, page map, encode page store, config and output register
// depends on scc_pkg
`timescale 1ns / 1ps

module scc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::scc_ctl_t ctl_i,
  output scc_pkg::scc_stat_t stat_o,
  input  logic [2:0]        in_cmd_i,
  input  logic [15:0]       in_unit_i,
  input  logic [7:0]        in_byte_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [15:0]       m_tdata_o,
  output logic [1:0]        m_tuser_o
);
  import scc_pkg::*;

  logic [15:0]       dec_mem [256];
  logic [PAGE_W-1:0] pidx_mem [256];
  logic [8:0]        enc_mem [ENC_DEPTH];

  logic [2:0]        cmd_q;
  logic [15:0]       unit_q;
  logic [7:0]        byte_q;
  logic [15:0]       dec_rd_q;
  logic [PAGE_W-1:0] pidx_rd_q;
  logic              pv_q;
  logic [8:0]        enc_rd_q;
  logic [255:0]      page_valid_q;
  logic [PU_W-1:0]   pages_used_q;
  logic              pending_q, pending_d;
  logic [ENC_AW-1:0] sweep_cnt_q;
  logic [15:0]       dec_repl_q;
  logic [7:0]        enc_repl_q;
  logic [15:0]       res_val_q;
  logic [1:0]        res_st_q;
  logic              m_tvalid_q;
  logic [15:0]       m_tdata_q;
  logic [1:0]        m_tuser_q;

  logic              is_ffd, full, is_rev, page_ok, alloc, enc_hit;
  logic              hi_sur, lo_sur;
  logic [PAGE_W-1:0] page;
  logic              dec_we, enc_we, pidx_we;
  logic [7:0]        dec_waddr;
  logic [15:0]       dec_wdata;
  logic [ENC_AW-1:0] enc_waddr;
  logic [8:0]        enc_wdata;
  logic [15:0]       look_val, enc_val, res_val_d;
  logic [1:0]        look_st, enc_st, res_st_d;

  assign is_ffd  = (unit_q == UNMAPPED_CHAR);
  assign full    = (pages_used_q == PAGES_FULL);
  assign is_rev  = ((cmd_q == CMD_LOAD_DEC) && !is_ffd) || (cmd_q == CMD_LOAD_NRT);
  assign page_ok = pv_q || !full;
  assign alloc   = ctl_i.exec && is_rev && !pv_q && !full;
  assign page    = pv_q ? pidx_rd_q : pages_used_q[PAGE_W-1:0];
  assign hi_sur  = (unit_q >= HI_SUR_MIN) && (unit_q <= HI_SUR_MAX);
  assign lo_sur  = (unit_q >= LO_SUR_MIN) && (unit_q <= LO_SUR_MAX);
  assign enc_hit = pv_q && enc_rd_q[8];

  always_comb begin
    dec_we    = 1'b0;
    dec_waddr = byte_q;
    dec_wdata = unit_q;
    enc_we    = 1'b0;
    enc_waddr = {page, unit_q[7:0]};
    enc_wdata = {1'b1, byte_q};
    if (ctl_i.sweep) begin
      dec_we    = 1'b1;
      dec_waddr = sweep_cnt_q[7:0];
      dec_wdata = UNMAPPED_CHAR;
      enc_we    = 1'b1;
      enc_waddr = sweep_cnt_q;
      enc_wdata = '0;
    end else if (ctl_i.exec) begin
      dec_we = (cmd_q == CMD_LOAD_DEC) && (is_ffd || page_ok);
      enc_we = is_rev && page_ok;
    end
  end

  assign pidx_we = alloc;

  always_ff @(posedge clk_i) begin
    if (dec_we) begin
      dec_mem[dec_waddr] <= dec_wdata;
    end
    if (ctl_i.cap) begin
      dec_rd_q <= dec_mem[in_byte_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pidx_we) begin
      pidx_mem[unit_q[15:8]] <= pages_used_q[PAGE_W-1:0];
    end
    if (ctl_i.cap) begin
      pidx_rd_q <= pidx_mem[in_unit_i[15:8]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_we) begin
      enc_mem[enc_waddr] <= enc_wdata;
    end
    if (ctl_i.exec) begin
      enc_rd_q <= enc_mem[{pidx_rd_q, unit_q[7:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q  <= in_cmd_i;
      unit_q <= in_unit_i;
      byte_q <= in_byte_i;
      pv_q   <= page_valid_q[in_unit_i[15:8]];
    end
    if (ctl_i.hold_load) begin
      res_val_q <= res_val_d;
      res_st_q  <= res_st_d;
    end
    if (ctl_i.push_new) begin
      m_tdata_q <= res_val_d;
      m_tuser_q <= res_st_d;
    end else if (ctl_i.push_held) begin
      m_tdata_q <= res_val_q;
      m_tuser_q <= res_st_q;
    end
  end

  always_comb begin
    look_val = '0;
    look_st  = ST_OK;
    case (cmd_q)
      CMD_LOAD_DEC: begin
        if (!is_ffd && !page_ok) look_st = ST_FULL;
      end
      CMD_LOAD_NRT: begin
        if (!page_ok) look_st = ST_FULL;
      end
      CMD_DECODE: begin
        if (dec_rd_q == UNMAPPED_CHAR) begin
          look_val = dec_repl_q;
          look_st  = ST_UNMAP;
        end else begin
          look_val = dec_rd_q;
        end
      end
      default: begin
        look_val = '0;
        look_st  = ST_OK;
      end
    endcase
  end

  assign enc_val   = {8'h00, enc_hit ? enc_rd_q[7:0] : enc_repl_q};
  assign enc_st    = enc_hit ? ST_OK : ST_UNMAP;
  assign res_val_d = ctl_i.res_sel_enc ? enc_val : look_val;
  assign res_st_d  = ctl_i.res_sel_enc ? enc_st : look_st;

  always_comb begin
    pending_d = pending_q;
    if (ctl_i.sweep_start || ctl_i.exec) begin
      pending_d = 1'b0;
    end else if (ctl_i.enc && !enc_hit && hi_sur) begin
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_valid_q <= '0;
      pages_used_q <= '0;
      pending_q    <= 1'b0;
      sweep_cnt_q  <= '0;
      dec_repl_q   <= DEC_REPL_RST;
      enc_repl_q   <= ENC_REPL_RST;
      m_tvalid_q   <= 1'b0;
    end else begin
      pending_q <= pending_d;
      if (ctl_i.sweep_start) begin
        page_valid_q <= '0;
        pages_used_q <= '0;
        sweep_cnt_q  <= '0;
      end else begin
        if (alloc) begin
          page_valid_q[unit_q[15:8]] <= 1'b1;
          pages_used_q               <= pages_used_q + PU_W'(1);
        end
        if (ctl_i.sweep) begin
          sweep_cnt_q <= sweep_cnt_q + ENC_AW'(1);
        end
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_DEC_REPL) begin
          dec_repl_q <= cfg_data_i;
        end else begin
          enc_repl_q <= cfg_data_i[7:0];
        end
      end
      if (ctl_i.push_new || ctl_i.push_held) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign stat_o.cmd_known  = (in_cmd_i <= CMD_ENCODE);
  assign stat_o.is_clear   = (in_cmd_i == CMD_CLEAR);
  assign stat_o.swallow    = (cmd_q == CMD_ENCODE) && pending_q && lo_sur;
  assign stat_o.need_enc   = (cmd_q == CMD_ENCODE) && !(pending_q && lo_sur);
  assign stat_o.sweep_last = (sweep_cnt_q == ENC_LAST);
  assign stat_o.out_free   = !m_tvalid_q || m_tready_i;

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

endmodule

// File: hdl/scc_ctrl.sv
// controller state machine sequencing capture, table update, encode lookup and sweep
// depends on scc_pkg
`timescale 1ns / 1ps

module scc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  scc_pkg::scc_stat_t stat_i,
  output scc_pkg::scc_ctl_t  ctl_o
);
  import scc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_ENC   = 3'd2;
  localparam logic [2:0] S_HOLD  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  logic [2:0] state_q, state_d;
  logic       clr_res_q, clr_res_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    ctl_o     = '0;
    state_d   = state_q;
    clr_res_d = clr_res_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i && stat_i.cmd_known) begin
          ctl_o.cap = 1'b1;
          if (stat_i.is_clear) begin
            ctl_o.sweep_start = 1'b1;
            clr_res_d         = 1'b1;
            state_d           = S_SWEEP;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        ctl_o.exec = 1'b1;
        if (stat_i.swallow) begin
          state_d = S_IDLE;
        end else if (stat_i.need_enc) begin
          state_d = S_ENC;
        end else if (stat_i.out_free) begin
          ctl_o.push_new = 1'b1;
          state_d        = S_IDLE;
        end else begin
          ctl_o.hold_load = 1'b1;
          state_d         = S_HOLD;
        end
      end
      S_ENC: begin
        ctl_o.enc         = 1'b1;
        ctl_o.res_sel_enc = 1'b1;
        if (stat_i.out_free) begin
          ctl_o.push_new = 1'b1;
          state_d        = S_IDLE;
        end else begin
          ctl_o.hold_load = 1'b1;
          state_d         = S_HOLD;
        end
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          ctl_o.push_held = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          clr_res_d = 1'b0;
          if (!clr_res_q) begin
            state_d = S_IDLE;
          end else if (stat_i.out_free) begin
            ctl_o.push_new = 1'b1;
            state_d        = S_IDLE;
          end else begin
            ctl_o.hold_load = 1'b1;
            state_d         = S_HOLD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      clr_res_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_res_q <= clr_res_d;
    end
  end

endmodule

// File: hdl/single_byte_charset_codec_top.sv
// decode/load: capture, S_LOOK; encode: capture, S_LOOK, S_ENC; clear: capture, sweep
// one command in flight; next accept once the result sits in the output register (none for a swallowed low surrogate)
// throughput set by the registered table reads: a new command waits until the last one is done
// after reset a sweep of MAX_PAGES*256 (2048) entries clears the tables, s_axis_tready_o low
// config writes are taken in any cycle; holds scc_ctrl and scc_dp, uses scc_pkg
`timescale 1ns / 1ps

module single_byte_charset_codec_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // code_unit[15:0], byte_value[23:16]
  input  logic [2:0]  s_axis_tuser_i,   // command[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // result_value[15:0]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import scc_pkg::*;

  scc_ctl_t  ctl;
  scc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  scc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_cmd_i    (s_axis_tuser_i),
    .in_unit_i   (s_axis_tdata_i[15:0]),
    .in_byte_i   (s_axis_tdata_i[23:16]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule

// File: hdl/scc_chk.sv
// port-level checker for the charset codec top, attached by bind
// depends on scc_pkg and single_byte_charset_codec_top_defines.svh
`timescale 1ns / 1ps
`include "single_byte_charset_codec_top_defines.svh"

module scc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        cfg_index_i,
  input logic [15:0] cfg_data_i
);
  import scc_pkg::*;

  // stalled result transaction keeps its payload
  `SCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // status never takes the unused code
  `SCC_ASSERT_NOW(a_status_range, m_axis_tvalid_o, (m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_UNMAP) || (m_axis_tuser_o == ST_FULL), "bad status code")

  // a dropped load reports a zero value
  `SCC_ASSERT_NOW(a_full_zero, m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL), m_axis_tdata_o == 16'h0000, "full status with nonzero value")

  // a known command occupies the block for at least the next cycle
  `SCC_ASSERT_NEXT(a_busy_after_cmd, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i <= CMD_ENCODE), !s_axis_tready_o, "input ready right after a command")

endmodule

bind single_byte_charset_codec_top scc_chk u_scc_chk (.*);
